### src/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timeout scheduler.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int SLOT_FIELD_W  = 4;
    localparam int DELAY_W       = 24;
    localparam int KIND_W        = 2;
    localparam int COUNT_W       = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARMED   = 2'd0,
        KIND_REFUSED = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_cmd_t;

endpackage
`default_nettype wire

### src/stq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_req_if
// Request channel: a tick or an arm of one timeout slot.
// ----------------------------------------------------------------------------
interface stq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  slot;
    logic [stq_pkg::DELAY_W-1:0]       delay_ms;

    modport source (output valid, output action, output slot, output delay_ms,
                    input ready);
    modport sink (input valid, input action, input slot, input delay_ms,
                  output ready);
endinterface
`default_nettype wire

### src/stq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_rsp_if
// Response channel: arm status or an expired slot.
// ----------------------------------------------------------------------------
interface stq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [stq_pkg::KIND_W-1:0]        kind;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  slot_out;
    logic [stq_pkg::COUNT_W-1:0]       armed_count;
    logic                              last;

    modport source (output valid, output kind, output slot_out, output armed_count,
                    output last, input ready);
    modport sink (input valid, input kind, input slot_out, input armed_count,
                  input last, output ready);
endinterface
`default_nettype wire

### src/stq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_cell
// One queue position: holds a deadline and a slot, compares the deadline
// against a broadcast value, and shifts right on insert or left on pop.
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire stq_pkg::cell_cmd_t          cmd,
    input  wire [TIME_BITS-1:0]              cmp_value,
    input  wire [TIME_BITS-1:0]              new_deadline,
    input  wire [stq_pkg::SLOT_FIELD_W-1:0]  new_slot,
    input  wire                              prev_valid,
    input  wire                              prev_le,
    input  wire [TIME_BITS-1:0]              prev_deadline,
    input  wire [stq_pkg::SLOT_FIELD_W-1:0]  prev_slot,
    input  wire                              next_valid,
    input  wire [TIME_BITS-1:0]              next_deadline,
    input  wire [stq_pkg::SLOT_FIELD_W-1:0]  next_slot,
    output logic                             valid,
    output logic                             le,
    output logic [TIME_BITS-1:0]             deadline,
    output logic [stq_pkg::SLOT_FIELD_W-1:0] slot
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [TIME_BITS-1:0]              deadline_reg;
    logic [TIME_BITS-1:0]              deadline_next;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  slot_reg;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  slot_next;

    assign le       = valid_reg && (deadline_reg <= cmp_value);
    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign slot     = slot_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        slot_next     = slot_reg;
        if (cmd.insert)
        begin
            valid_next = valid_reg | prev_valid;
            if (!le)
            begin
                if (prev_le)
                begin
                    deadline_next = new_deadline;
                    slot_next     = new_slot;
                end
                else
                begin
                    deadline_next = prev_deadline;
                    slot_next     = prev_slot;
                end
            end
        end
        else if (cmd.pop)
        begin
            valid_next    = next_valid;
            deadline_next = next_deadline;
            slot_next     = next_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        slot_reg     <= slot_next;
    end

endmodule
`default_nettype wire

### src/sorted_timeout_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timeout_scheduler
// Millisecond time base with a deadline-sorted queue of armed timeout slots.
// ----------------------------------------------------------------------------
// An arm request is taken while idle: every queue cell compares its deadline
// with the new one and the whole row shifts in the same cycle, and the status
// transfer is held in the output register. A tick advances the time counter,
// then the expired slots are popped from the head cell of the row one per
// cycle while the response side is free; a stalled response side stretches
// the drain. No new request is taken while a tick is being drained.
module sorted_timeout_scheduler #(
    parameter int SLOTS     = stq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    stq_req_if.sink    req,
    stq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    stq_pkg::state_t                   state_reg;
    stq_pkg::state_t                   state_next;
    logic [TIME_BITS-1:0]              now_reg;
    logic [TIME_BITS-1:0]              now_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [SLOTS-1:0]                  armed_reg;
    logic [SLOTS-1:0]                  armed_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    stq_pkg::kind_t                    out_kind_reg;
    stq_pkg::kind_t                    out_kind_next;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  out_slot_reg;
    logic [stq_pkg::SLOT_FIELD_W-1:0]  out_slot_next;
    logic [stq_pkg::COUNT_W-1:0]       out_count_reg;
    logic [stq_pkg::COUNT_W-1:0]       out_count_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic                              cell_valid [SLOTS];
    logic                              cell_le    [SLOTS];
    logic [TIME_BITS-1:0]              cell_dl    [SLOTS];
    logic [stq_pkg::SLOT_FIELD_W-1:0]  cell_slot  [SLOTS];
    logic [SLOTS-1:0]                  valid_vec;

    stq_pkg::cell_cmd_t                cmd;
    logic [TIME_BITS-1:0]              new_dl;
    logic [TIME_BITS-1:0]              cmp_value;
    logic [SLOTS-1:0]                  req_dec;
    logic [SLOTS-1:0]                  head_dec;
    logic                              in_range;
    logic                              refuse;
    logic                              out_free;
    logic                              accept;
    logic                              arm_ok;
    logic                              tick;
    logic                              emit;

    assign new_dl    = now_reg + TIME_BITS'(req.delay_ms);
    assign cmp_value = (state_reg == stq_pkg::ST_IDLE) ? new_dl : now_reg;
    assign in_range  = 32'(req.slot) < SLOTS;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            req_dec[i]   = 32'(req.slot) == i;
            head_dec[i]  = 32'(cell_slot[0]) == i;
            valid_vec[i] = cell_valid[i];
        end
    end

    assign refuse = !in_range || (|(armed_reg & req_dec)) ||
                    (count_reg >= CNT_W'(SLOTS));
    assign out_free = !out_valid_reg || rsp.ready;

    // Handshake and cell commands.
    always_comb
    begin
        req.ready  = (state_reg == stq_pkg::ST_IDLE) && out_free;
        accept     = req.valid && req.ready;
        arm_ok     = accept && req.action && !refuse;
        tick       = accept && !req.action;
        emit       = (state_reg == stq_pkg::ST_DRAIN) && cell_le[0] && out_free;
        cmd.insert = arm_ok;
        cmd.pop    = emit;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (tick)
                begin
                    state_next = stq_pkg::ST_DRAIN;
                end
            end
            stq_pkg::ST_DRAIN:
            begin
                if (!cell_le[0] || (out_free && !cell_le[1]))
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next       = tick ? now_reg + TIME_BITS'(1) : now_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        if (accept && req.action)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = req.slot;
            out_last_next  = 1'b1;
            if (refuse)
            begin
                out_kind_next  = stq_pkg::KIND_REFUSED;
                out_count_next = stq_pkg::COUNT_W'(count_reg);
            end
            else
            begin
                count_next     = count_reg + CNT_W'(1);
                armed_next     = armed_reg | req_dec;
                out_kind_next  = stq_pkg::KIND_ARMED;
                out_count_next = stq_pkg::COUNT_W'(count_reg + CNT_W'(1));
            end
        end
        else if (emit)
        begin
            count_next     = count_reg - CNT_W'(1);
            armed_next     = armed_reg & ~head_dec;
            out_valid_next = 1'b1;
            out_kind_next  = stq_pkg::KIND_EXPIRED;
            out_slot_next  = cell_slot[0];
            out_count_next = stq_pkg::COUNT_W'(count_reg - CNT_W'(1));
            out_last_next  = !cell_le[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stq_pkg::ST_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.slot_out    = out_slot_reg;
    assign rsp.armed_count = out_count_reg;
    assign rsp.last        = out_last_reg;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        logic                              p_valid;
        logic                              p_le;
        logic [TIME_BITS-1:0]              p_dl;
        logic [stq_pkg::SLOT_FIELD_W-1:0]  p_slot;
        logic                              n_valid;
        logic [TIME_BITS-1:0]              n_dl;
        logic [stq_pkg::SLOT_FIELD_W-1:0]  n_slot;

        if (g == 0)
        begin : g_first
            assign p_valid = 1'b1;
            assign p_le    = 1'b1;
            assign p_dl    = new_dl;
            assign p_slot  = req.slot;
        end
        else
        begin : g_mid
            assign p_valid = cell_valid[g-1];
            assign p_le    = cell_le[g-1];
            assign p_dl    = cell_dl[g-1];
            assign p_slot  = cell_slot[g-1];
        end

        if (g == SLOTS - 1)
        begin : g_end
            assign n_valid = 1'b0;
            assign n_dl    = new_dl;
            assign n_slot  = req.slot;
        end
        else
        begin : g_inner
            assign n_valid = cell_valid[g+1];
            assign n_dl    = cell_dl[g+1];
            assign n_slot  = cell_slot[g+1];
        end

        stq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .cmp_value     (cmp_value),
            .new_deadline  (new_dl),
            .new_slot      (req.slot),
            .prev_valid    (p_valid),
            .prev_le       (p_le),
            .prev_deadline (p_dl),
            .prev_slot     (p_slot),
            .next_valid    (n_valid),
            .next_deadline (n_dl),
            .next_slot     (n_slot),
            .valid         (cell_valid[g]),
            .le            (cell_le[g]),
            .deadline      (cell_dl[g]),
            .slot          (cell_slot[g])
        );
    end

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_vec))
        else $error("queue length differs from occupied cells");

    a_armed_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(armed_reg) == 32'(count_reg))
        else $error("armed slots differ from queue length");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid[0] && cell_valid[1]) |-> (cell_dl[0] <= cell_dl[1]))
        else $error("queue head out of deadline order");

    a_drain_pops_due: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("expiry transfer did not shorten the queue");

endmodule
`default_nettype wire
